// ----- rtl/adr_pkg.sv -----
package adr_pkg;

  localparam int POS_W = 32;
  localparam int AXIS_W = 4;
  localparam int AXIS_SLOTS = 1 << AXIS_W;
  localparam int LEN_W = 10;
  localparam int CNT_W = LEN_W + 1;
  localparam int BIT_CNT_W = 5;

  localparam logic [LEN_W-1:0] RAMP_PERIODS_RST = 10'd64;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = 5'(POS_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_CALC = 4'b1000
  } state_t;

endpackage

// ----- rtl/axis_decel_ramp_top.sv -----
// Controlled linear stop for up to 16 position-commanded axes. One item per axis per
// servo period, the last flagged with last_in_period; each item gives exactly one result.
// An item passes accept with table read, prepare and result; a valid axis item in the first
// period of a stop ramp also passes a divide step: its step is speed / ramp_periods worked
// out by a bit-serial restoring divider that shifts the 32-bit speed magnitude through one
// quotient bit per cycle. The result sits in an output register, so the next item is taken
// while it still waits. ramp_periods = 0 acts as 1; write it only while the block is idle.
module axis_decel_ramp_top #(
  parameter int AXIS_COUNT = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [adr_pkg::LEN_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic [adr_pkg::AXIS_W-1:0]        axis,
  input  logic signed [adr_pkg::POS_W-1:0]  cmd_pos,
  input  logic                              last_in_period,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [adr_pkg::AXIS_W-1:0]        axis_out,
  output logic signed [adr_pkg::POS_W-1:0]  new_target,
  output logic                              ramping,
  output logic                              motion_cut,
  output logic                              ramp_done
);

  localparam logic [8:0] AXIS_LIM = 9'(AXIS_COUNT);

  adr_pkg::state_t state;

  logic [adr_pkg::LEN_W-1:0] ramp_periods;
  logic [adr_pkg::CNT_W-1:0] ramp_count;
  logic                      none_moving;

  // latched beat
  logic                              func_q;
  logic [adr_pkg::AXIS_W-1:0]        axis_q;
  logic signed [adr_pkg::POS_W-1:0]  target_q;
  logic                              last_q;

  // per-axis tables, an entry without its valid bit reads as zero
  logic [adr_pkg::POS_W-1:0] start_mem [adr_pkg::AXIS_SLOTS];
  logic [adr_pkg::POS_W-1:0] cur_mem   [adr_pkg::AXIS_SLOTS];
  logic [adr_pkg::POS_W-1:0] step_mem  [adr_pkg::AXIS_SLOTS];
  logic [adr_pkg::POS_W-1:0] prev_mem  [adr_pkg::AXIS_SLOTS];
  logic [adr_pkg::AXIS_SLOTS-1:0] ramp_vld;
  logic [adr_pkg::AXIS_SLOTS-1:0] prev_vld;

  // working registers
  logic signed [adr_pkg::POS_W-1:0] start_q;
  logic signed [adr_pkg::POS_W-1:0] cur_q;
  logic signed [adr_pkg::POS_W-1:0] step_q;
  logic [adr_pkg::POS_W-1:0]        div_num;
  logic [adr_pkg::LEN_W-1:0]        div_rem;
  logic [adr_pkg::LEN_W-1:0]        len_q;
  logic [adr_pkg::BIT_CNT_W-1:0]    bit_cnt;
  logic signed [adr_pkg::POS_W-1:0] start_rd;
  logic signed [adr_pkg::POS_W-1:0] cur_rd;
  logic signed [adr_pkg::POS_W-1:0] step_rd;
  logic signed [adr_pkg::POS_W-1:0] prev_rd;

  logic                              axis_ok;
  logic                              active;
  logic [adr_pkg::LEN_W-1:0]         len;
  logic signed [adr_pkg::POS_W-1:0]  speed;
  logic [adr_pkg::POS_W-1:0]         speed_mag;
  logic [adr_pkg::LEN_W:0]           rem_sh;
  logic                              q_bit;
  logic [adr_pkg::POS_W-1:0]         quot;
  logic signed [adr_pkg::POS_W-1:0]  step_next;
  logic signed [adr_pkg::POS_W-1:0]  diff;
  logic signed [adr_pkg::POS_W-1:0]  cur_next;
  logic                              moving;
  logic                              stopped_now;
  logic [adr_pkg::CNT_W-1:0]         count_inc;
  logic [adr_pkg::CNT_W-1:0]         ramp_len2;
  logic                              out_free;

  assign in_stall = (state != adr_pkg::ST_IDLE);
  assign axis_ok = ({5'b0, axis_q} < AXIS_LIM);
  assign active = (ramp_count != '0);
  assign len = (ramp_periods == '0) ? adr_pkg::LEN_W'(1) : ramp_periods;
  assign out_free = !out_valid || !out_stall;

  assign speed = target_q - prev_rd;
  assign speed_mag = speed[adr_pkg::POS_W-1] ? (~speed + 1'b1) : speed;

  // one restoring step: bring in the next dividend bit, msb first
  assign rem_sh = {div_rem, div_num[adr_pkg::POS_W-1]};
  assign q_bit = (rem_sh >= {1'b0, len_q});
  assign quot = {div_num[adr_pkg::POS_W-2:0], q_bit};

  always_comb begin
    if (quot != '0) begin
      step_next = start_q[adr_pkg::POS_W-1] ? (~quot + 1'b1) : quot;
    end else if (start_q > 0) begin
      step_next = adr_pkg::POS_W'(1);
    end else if (start_q < 0) begin
      step_next = '1;
    end else begin
      step_next = '0;
    end
  end

  // shrink the speed, never past zero
  always_comb begin
    diff = cur_q - step_q;
    cur_next = diff;
    if (start_q > 0 && diff < 0) begin
      cur_next = '0;
    end
    if (start_q < 0 && diff > 0) begin
      cur_next = '0;
    end
  end

  assign moving = active && axis_ok && (cur_next != '0);
  assign stopped_now = none_moving && !moving;
  assign count_inc = ramp_count + 1'b1;
  assign ramp_len2 = {len, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_periods <= adr_pkg::RAMP_PERIODS_RST;
    end else if (cfg_wr_en) begin
      ramp_periods <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == adr_pkg::ST_CALC && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adr_pkg::ST_IDLE;
      ramp_count <= '0;
      none_moving <= 1'b1;
      ramp_vld <= '0;
      prev_vld <= '0;
    end else begin
      case (state)
        adr_pkg::ST_IDLE: begin
          if (in_valid) begin
            func_q <= func;
            axis_q <= axis;
            target_q <= cmd_pos;
            last_q <= last_in_period;
            start_rd <= ramp_vld[axis] ? start_mem[axis] : '0;
            cur_rd <= ramp_vld[axis] ? cur_mem[axis] : '0;
            step_rd <= ramp_vld[axis] ? step_mem[axis] : '0;
            prev_rd <= prev_vld[axis] ? prev_mem[axis] : '0;
            state <= adr_pkg::ST_PREP;
          end
        end
        adr_pkg::ST_PREP: begin
          len_q <= len;
          if (ramp_count == '0 && func_q) begin
            // ramp opens at this beat, so it is a first-period beat
            ramp_count <= adr_pkg::CNT_W'(1);
            none_moving <= 1'b1;
          end
          if (axis_ok && ((ramp_count == '0 && func_q) || ramp_count == adr_pkg::CNT_W'(1)))
          begin
            start_q <= speed;
            cur_q <= speed;
            div_num <= speed_mag;
            div_rem <= '0;
            bit_cnt <= '0;
            state <= adr_pkg::ST_DIV;
          end else begin
            start_q <= start_rd;
            cur_q <= cur_rd;
            step_q <= step_rd;
            state <= adr_pkg::ST_CALC;
          end
        end
        adr_pkg::ST_DIV: begin
          div_num <= quot;
          div_rem <= q_bit ? adr_pkg::LEN_W'(rem_sh - {1'b0, len_q})
                           : adr_pkg::LEN_W'(rem_sh);
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == adr_pkg::LAST_BIT) begin
            step_q <= step_next;
            start_mem[axis_q] <= start_q;
            step_mem[axis_q] <= step_next;
            ramp_vld[axis_q] <= 1'b1;
            state <= adr_pkg::ST_CALC;
          end
        end
        adr_pkg::ST_CALC: begin
          if (out_free) begin
            axis_out <= axis_q;
            motion_cut <= active && last_q && (ramp_count == adr_pkg::CNT_W'(1));
            ramp_done <= active && last_q && (count_inc >= ramp_len2 || stopped_now);
            if (active && axis_ok) begin
              cur_mem[axis_q] <= cur_next;
              new_target <= target_q + cur_next;
              ramping <= 1'b1;
            end else begin
              new_target <= target_q;
              ramping <= 1'b0;
            end
            if (!active && axis_ok) begin
              prev_mem[axis_q] <= target_q;
              prev_vld[axis_q] <= 1'b1;
            end
            if (active && last_q) begin
              none_moving <= 1'b1;
              if (count_inc >= ramp_len2 || stopped_now) begin
                ramp_count <= '0;
              end else begin
                ramp_count <= count_inc;
              end
            end else begin
              none_moving <= stopped_now;
            end
            state <= adr_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= adr_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- bench/tb_axis_decel_ramp_top.sv -----
module tb_axis_decel_ramp_top;

  localparam int AXES = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 290;
  localparam int HOLD_AT_ITEM = 500;
  localparam logic FUNC_RUN = 1'b0;
  localparam logic FUNC_STOP = 1'b1;

  typedef struct packed {
    logic [adr_pkg::AXIS_W-1:0] ax;
    logic [adr_pkg::POS_W-1:0]  tgt;
    logic                       rmp;
    logic                       cut;
    logic                       done;
  } target_beat_t;

  class stop_ramp_scoreboard;
    logic [adr_pkg::POS_W-1:0] open_spd[AXES];
    logic [adr_pkg::POS_W-1:0] cur_spd[AXES];
    logic [adr_pkg::POS_W-1:0] spd_step[AXES];
    logic [adr_pkg::POS_W-1:0] prev_tgt[AXES];
    int unsigned               period_no;
    bit                        none_moving;
    logic [adr_pkg::LEN_W-1:0] len_reg;
    target_beat_t              expected_targets[$];
    int                        mismatches;

    function new();
      for (int i = 0; i < AXES; i++) begin
        open_spd[i] = '0;
        cur_spd[i] = '0;
        spd_step[i] = '0;
        prev_tgt[i] = '0;
      end
      period_no = 0;
      none_moving = 1'b1;
      len_reg = adr_pkg::RAMP_PERIODS_RST;
      mismatches = 0;
    endfunction

    function void set_ramp_periods(logic [adr_pkg::LEN_W-1:0] v);
      len_reg = v;
    endfunction

    function bit ramp_active();
      return period_no != 0;
    endfunction

    function int pending();
      return expected_targets.size();
    endfunction

    // works out the commanded target for one accepted beat
    function void take_command(logic f, logic [adr_pkg::AXIS_W-1:0] a,
                               logic [adr_pkg::POS_W-1:0] t, logic l);
      int unsigned               len;
      target_beat_t              e;
      longint                    spd;
      longint                    stp;
      int                        start_s;
      int                        next_s;
      logic [adr_pkg::POS_W-1:0] nx;
      len = (len_reg == 0) ? 1 : len_reg;
      e.ax = a;
      e.tgt = t;
      e.rmp = 1'b0;
      e.cut = 1'b0;
      e.done = 1'b0;
      if (period_no == 0 && f == FUNC_STOP) begin
        period_no = 1;
        none_moving = 1'b1;
      end
      if (period_no != 0) begin
        if (period_no == 1) begin
          open_spd[a] = t - prev_tgt[a];
          cur_spd[a] = open_spd[a];
          spd = longint'($signed(cur_spd[a]));
          stp = spd / longint'(len);
          if (stp == 0) stp = (spd > 0) ? 1 : ((spd < 0) ? -1 : 0);
          spd_step[a] = stp[adr_pkg::POS_W-1:0];
        end
        nx = cur_spd[a] - spd_step[a];
        start_s = $signed(open_spd[a]);
        next_s = $signed(nx);
        // speed may not cross zero
        if ((start_s > 0 && next_s < 0) || (start_s < 0 && next_s > 0)) nx = '0;
        cur_spd[a] = nx;
        e.tgt = t + nx;
        if (nx != 0) none_moving = 1'b0;
        e.rmp = 1'b1;
        if (l) begin
          if (period_no == 1) e.cut = 1'b1;
          period_no++;
          if (period_no >= 2 * len || none_moving) begin
            e.done = 1'b1;
            period_no = 0;
          end
          none_moving = 1'b1;
        end
      end else begin
        prev_tgt[a] = t;
      end
      expected_targets.push_back(e);
    endfunction

    function void check_target(logic [adr_pkg::AXIS_W-1:0] a, logic [adr_pkg::POS_W-1:0] t,
                               logic r, logic c, logic d);
      target_beat_t e;
      target_beat_t got;
      got.ax = a;
      got.tgt = t;
      got.rmp = r;
      got.cut = c;
      got.done = d;
      if (expected_targets.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: axis %0d target %0d", a, $signed(t));
        mismatches++;
      end else begin
        e = expected_targets.pop_front();
        if (got !== e) begin
          if (mismatches < 10)
            $display("mismatch: exp %0d %0d %0b%0b%0b got %0d %0d %0b%0b%0b",
                     e.ax, $signed(e.tgt), e.rmp, e.cut, e.done,
                     got.ax, $signed(got.tgt), got.rmp, got.cut, got.done);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             cfg_wr_en;
  logic [adr_pkg::LEN_W-1:0]        cfg_wr_data;
  logic                             in_valid;
  logic                             in_stall;
  logic                             func;
  logic [adr_pkg::AXIS_W-1:0]       axis;
  logic signed [adr_pkg::POS_W-1:0] cmd_pos;
  logic                             last_in_period;
  logic                             out_valid;
  logic                             out_stall;
  logic [adr_pkg::AXIS_W-1:0]       axis_out;
  logic signed [adr_pkg::POS_W-1:0] new_target;
  logic                             ramping;
  logic                             motion_cut;
  logic                             ramp_done;

  stop_ramp_scoreboard sb;
  bit calm;
  bit hold_req;
  int random_sent;
  int idle_cycles;

  axis_decel_ramp_top #(.AXIS_COUNT(AXES)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .axis(axis),
    .cmd_pos(cmd_pos),
    .last_in_period(last_in_period),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .axis_out(axis_out),
    .new_target(new_target),
    .ramping(ramping),
    .motion_cut(motion_cut),
    .ramp_done(ramp_done)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_target(axis_out, new_target, ramping, motion_cut, ramp_done);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver back-pressure
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if (!calm && !rst && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 13);
        out_stall = 1'b1;
        repeat (burst) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_cmd(logic f, logic [adr_pkg::AXIS_W-1:0] a,
                          logic [adr_pkg::POS_W-1:0] t, logic l);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    func = f;
    axis = a;
    cmd_pos = t;
    last_in_period = l;
    do @(posedge clk); while (in_stall);
    sb.take_command(f, a, t, l);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_ramp_periods(logic [adr_pkg::LEN_W-1:0] v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_ramp_periods(v);
  endtask

  // single-axis periods until the ramp has run out, so the register can change
  task automatic finish_ramp(logic [adr_pkg::AXIS_W-1:0] a, logic [adr_pkg::POS_W-1:0] t);
    while (sb.ramp_active()) send_cmd(FUNC_RUN, a, t, 1'b1);
  endtask

  function automatic logic [adr_pkg::POS_W-1:0] pick_speed(int unsigned len);
    int v;
    int vmax;
    vmax = (len > 40) ? 30 : 5000;
    case ($urandom_range(0, 3))
      0: v = 0;
      1, 2: begin
        v = $urandom_range(1, vmax);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = (len > 40) ? $urandom_range(0, 3) : $urandom;
    endcase
    return v;
  endfunction

  task automatic run_phase(int n_items, int unsigned len);
    int                         count;
    int                         ax_cnt;
    int                         quiet;
    int                         stop_k;
    int                         n_noise;
    int                         tail;
    bit                         hold_pos;
    bit                         stopping;
    logic [adr_pkg::AXIS_W-1:0] axes[4];
    logic [adr_pkg::POS_W-1:0]  pos[4];
    logic [adr_pkg::POS_W-1:0]  vel[4];
    logic                       f;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(0, 9) < 2) begin
        // noise: random beats and period marks, stop requests only with short ramps
        n_noise = $urandom_range(1, 5);
        repeat (n_noise) begin
          send_cmd((len <= 40 && $urandom_range(0, 3) == 0) ? FUNC_STOP : FUNC_RUN,
                   adr_pkg::AXIS_W'($urandom_range(0, AXES - 1)), $urandom,
                   1'($urandom_range(0, 1)));
          count++;
        end
      end else begin
        ax_cnt = $urandom_range(1, 4);
        for (int k = 0; k < ax_cnt; k++) begin
          axes[k] = adr_pkg::AXIS_W'($urandom_range(0, AXES - 1));
          pos[k] = $urandom;
          vel[k] = pick_speed(len);
        end
        quiet = $urandom_range(1, 5);
        stop_k = $urandom_range(0, ax_cnt - 1);
        hold_pos = 1'($urandom_range(0, 1));
        tail = $urandom_range(0, 2);
        stopping = 1'b0;
        while (quiet > 0 || sb.ramp_active() || !stopping || tail > 0) begin
          if (quiet == 0 && stopping && !sb.ramp_active()) tail--;
          for (int k = 0; k < ax_cnt; k++) begin
            if (!(stopping && hold_pos)) pos[k] = pos[k] + vel[k];
            if (quiet == 0 && !stopping && k == stop_k) begin
              f = FUNC_STOP;
              stopping = 1'b1;
            end else if (stopping && $urandom_range(0, 9) == 0) begin
              f = FUNC_STOP;
            end else begin
              f = FUNC_RUN;
            end
            send_cmd(f, axes[k], pos[k], k == ax_cnt - 1);
            count++;
            random_sent++;
            if (random_sent == HOLD_AT_ITEM) hold_req = 1'b1;
          end
          if (quiet > 0) quiet--;
        end
      end
    end
    finish_ramp(axes[0], pos[0]);
  endtask

  initial begin
    logic [adr_pkg::LEN_W-1:0] cfgs[7];
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    random_sent = 0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    func = FUNC_RUN;
    axis = '0;
    cmd_pos = '0;
    last_in_period = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_ramp_periods(10'd4);
    send_cmd(FUNC_RUN, 4'd0, 32'd100, 1'b0);
    send_cmd(FUNC_RUN, 4'd15, 32'h8000_0000, 1'b1);
    send_cmd(FUNC_RUN, 4'd0, 32'd1100, 1'b0);
    // stop request on the last beat of a period, speed of minus one
    send_cmd(FUNC_STOP, 4'd15, 32'h7FFF_FFFF, 1'b1);
    send_cmd(FUNC_RUN, 4'd0, 32'h7FFF_FFFF, 1'b0);
    send_cmd(FUNC_RUN, 4'd15, 32'hFFFF_FFFF, 1'b1);
    send_cmd(FUNC_STOP, 4'd0, 32'h8000_0FFF, 1'b0);
    send_cmd(FUNC_RUN, 4'd15, 32'h0000_0000, 1'b1);
    // repeated requests while ramping are ignored
    while (sb.ramp_active()) begin
      send_cmd(FUNC_STOP, 4'd0, 32'h8000_0FFF, 1'b0);
      send_cmd(FUNC_RUN, 4'd15, 32'h0000_0000, 1'b1);
    end
    // positive speed that wraps the target
    send_cmd(FUNC_RUN, 4'd15, 32'h7FFF_FF00, 1'b1);
    send_cmd(FUNC_STOP, 4'd15, 32'h7FFF_FFF0, 1'b1);
    finish_ramp(4'd15, 32'h7FFF_FFF0);
    // negative speed
    send_cmd(FUNC_RUN, 4'd3, 32'h0000_0040, 1'b1);
    send_cmd(FUNC_STOP, 4'd3, 32'hFFFF_FFC0, 1'b1);
    finish_ramp(4'd3, 32'hFFFF_FFC0);
    settle();

    cfgs[0] = 10'd1;
    cfgs[1] = 10'd0;
    cfgs[2] = 10'd1023;
    cfgs[3] = 10'd5;
    cfgs[4] = adr_pkg::LEN_W'($urandom_range(1, 1023));
    cfgs[5] = 10'd16;
    cfgs[6] = adr_pkg::RAMP_PERIODS_RST;
    for (int p = 0; p < 7; p++) begin
      if (p == 6) calm = 1'b1;
      write_ramp_periods(cfgs[p]);
      run_phase(PHASE_ITEMS, (cfgs[p] == 0) ? 1 : cfgs[p]);
      settle();
    end

    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
